>>> rtl/hsm_pkg.sv
// ----------------------------------------------------------------------------
// hsm_pkg
// Shared types, codes and the reconcile function of the hart state manager.
// ----------------------------------------------------------------------------
package hsm_pkg;

	// widest hart index the design supports (NUM_HARTS up to 64)
	localparam int unsigned HART_IDX_W = 6;

	// configuration register indexes
	typedef enum logic [1:0] {
		CFG_HART_COUNT    = 2'd0,
		CFG_ID_BASE       = 2'd1,
		CFG_SUPPORTED_OPS = 2'd2
	} cfg_idx_t;

	// request function codes
	typedef enum logic [2:0] {
		FN_START   = 3'd0,
		FN_STOP    = 3'd1,
		FN_SUSPEND = 3'd2,
		FN_QUERY   = 3'd3,
		FN_POLL    = 3'd4
	} func_t;

	// software hart state
	typedef enum logic [2:0] {
		HS_UNKNOWN    = 3'd0,
		HS_STOPPED    = 3'd1,
		HS_START_PEND = 3'd2,
		HS_STARTED    = 3'd3,
		HS_STOP_PEND  = 3'd4,
		HS_SUSP_PEND  = 3'd5,
		HS_SUSPENDED  = 3'd6
	} hs_t;

	// sampled hardware state
	typedef enum logic [1:0] {
		HW_STARTED   = 2'd0,
		HW_STOPPED   = 2'd1,
		HW_SUSPENDED = 2'd2
	} hw_t;

	// response status
	typedef enum logic [2:0] {
		RC_OK      = 3'd0,
		RC_INVALID = 3'd1,
		RC_UNSUPP  = 3'd2,
		RC_ALREADY = 3'd3,
		RC_DENIED  = 3'd4,
		RC_PREPARE = 3'd5
	} rc_t;

	// finalize event
	typedef enum logic [1:0] {
		EV_NONE    = 2'd0,
		EV_START   = 2'd1,
		EV_STOP    = 2'd2,
		EV_SUSPEND = 2'd3
	} ev_t;

	// back end sequencer
	typedef enum logic {
		BK_FETCH = 1'b0,
		BK_EXEC  = 1'b1
	} bk_state_t;

	typedef struct packed {
		logic [2:0]  func;
		logic [31:0] hart_id;
		logic [63:0] target_addr;
		logic [31:0] suspend_kind;
		logic        prepare_fail;
		logic [1:0]  hw_sample;
	} req_t;

	typedef struct packed {
		logic [2:0]  status;
		logic [2:0]  hart_state;
		logic [1:0]  finalize_kind;
		logic [63:0] finalize_addr;
		logic [31:0] finalize_suspend_kind;
	} rsp_t;

	typedef struct packed {
		logic [3:0]  harts_used;
		logic [31:0] id_base;
		logic [2:0]  supported_ops;
	} cfg_t;

	// classified request as queued between front and back
	typedef struct packed {
		logic [2:0]            func;
		logic                  func_ok;
		logic                  hart_ok;
		logic                  op_supported;
		logic [HART_IDX_W-1:0] hart_idx;
		logic [63:0]           target_addr;
		logic [31:0]           suspend_kind;
		logic                  prepare_fail;
		logic [1:0]            hw_sample;
	} cmd_t;

	typedef struct packed {
		hs_t mode;
		ev_t ev;
	} recon_t;

	// settle the software state against the sampled hardware state
	function automatic recon_t reconcile(hs_t m, logic [1:0] hw);
		recon_t r;
		r.mode = m;
		r.ev   = EV_NONE;
		unique case (m)
			HS_UNKNOWN: begin
				if (hw == HW_STARTED)
					r.mode = HS_STARTED;
				else if (hw == HW_SUSPENDED)
					r.mode = HS_SUSPENDED;
				else
					r.mode = HS_STOPPED;
			end
			HS_START_PEND: begin
				if (hw == HW_STARTED) begin
					r.mode = HS_STARTED;
					r.ev   = EV_START;
				end
			end
			HS_STOP_PEND: begin
				if (hw == HW_STOPPED || hw == HW_SUSPENDED) begin
					r.mode = HS_STOPPED;
					r.ev   = EV_STOP;
				end
			end
			HS_SUSP_PEND: begin
				if (hw == HW_SUSPENDED) begin
					r.mode = HS_SUSPENDED;
					r.ev   = EV_SUSPEND;
				end
			end
			HS_SUSPENDED: begin
				if (hw == HW_STARTED)
					r.mode = HS_STARTED;
			end
			default: begin
				r.mode = m;
			end
		endcase
		return r;
	endfunction

endpackage

>>> rtl/hsm_front.sv
// ----------------------------------------------------------------------------
// hsm_front
// Takes request beats, maps the hart id to an index and classifies the
// function against the enabled operations.
// ----------------------------------------------------------------------------
module hsm_front #(
	parameter int unsigned NUM_HARTS = 8
) (
	input  logic           req_valid,
	output logic           req_ready,
	input  hsm_pkg::req_t  req,
	input  hsm_pkg::cfg_t  cfg,
	output logic           push_valid,
	input  logic           push_ready,
	output hsm_pkg::cmd_t  cmd
);

	logic [31:0] rel_idx;
	logic        in_range;
	logic        op_sup;

	// id to index, 32-bit wrap
	assign rel_idx  = req.hart_id - cfg.id_base;
	assign in_range = (rel_idx < {28'd0, cfg.harts_used}) && (rel_idx < 32'(NUM_HARTS));

	// operation enable per function
	always_comb begin
		op_sup = 1'b1;
		if (req.func == hsm_pkg::FN_START)
			op_sup = cfg.supported_ops[0];
		else if (req.func == hsm_pkg::FN_STOP)
			op_sup = cfg.supported_ops[1];
		else if (req.func == hsm_pkg::FN_SUSPEND)
			op_sup = cfg.supported_ops[2];
	end

	// classified command
	always_comb begin
		cmd.func         = req.func;
		cmd.func_ok      = (req.func <= hsm_pkg::FN_POLL);
		cmd.hart_ok      = in_range;
		cmd.op_supported = op_sup;
		cmd.hart_idx     = in_range ? rel_idx[hsm_pkg::HART_IDX_W-1:0] : '0;
		cmd.target_addr  = req.target_addr;
		cmd.suspend_kind = req.suspend_kind;
		cmd.prepare_fail = req.prepare_fail;
		cmd.hw_sample    = req.hw_sample;
	end

	assign push_valid = req_valid;
	assign req_ready  = push_ready;

endmodule

>>> rtl/hsm_queue.sv
// ----------------------------------------------------------------------------
// hsm_queue
// Two-entry command queue between the front and back ends.
// ----------------------------------------------------------------------------
module hsm_queue (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          push_valid,
	output logic          push_ready,
	input  hsm_pkg::cmd_t push_cmd,
	output logic          pop_valid,
	input  logic          pop_ready,
	output hsm_pkg::cmd_t pop_cmd
);

	hsm_pkg::cmd_t entry_q [2];
	logic          wr_ptr_q;
	logic          rd_ptr_q;
	logic [1:0]    count_q;
	logic          push;
	logic          pop;

	assign push_ready = (count_q != 2'd2);
	assign pop_valid  = (count_q != 2'd0);
	assign push       = push_valid && push_ready;
	assign pop        = pop_valid && pop_ready;
	assign pop_cmd    = entry_q[rd_ptr_q];

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (push)
				wr_ptr_q <= ~wr_ptr_q;
			if (pop)
				rd_ptr_q <= ~rd_ptr_q;
			if (push && !pop)
				count_q <= count_q + 2'd1;
			else if (pop && !push)
				count_q <= count_q - 2'd1;
		end
	end

	// entry storage
	always_ff @(posedge clk) begin
		if (push)
			entry_q[wr_ptr_q] <= push_cmd;
	end

endmodule

>>> rtl/hsm_back.sv
// ----------------------------------------------------------------------------
// hsm_back
// Reads the per-hart state table, checks and carries out the command,
// writes the table back and registers the response beat.
// ----------------------------------------------------------------------------
module hsm_back #(
	parameter int unsigned NUM_HARTS = 8
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          cmd_valid,
	output logic          cmd_ready,
	input  hsm_pkg::cmd_t cmd,
	output logic          rsp_valid,
	input  logic          rsp_ready,
	output hsm_pkg::rsp_t rsp
);

	localparam int unsigned IDX_W = (NUM_HARTS > 1) ? $clog2(NUM_HARTS) : 1;

	// state table memories
	logic [2:0]  mode_mem   [NUM_HARTS];
	logic [63:0] start_mem  [NUM_HARTS];
	logic [63:0] resume_mem [NUM_HARTS];
	logic [31:0] skind_mem  [NUM_HARTS];
	logic [NUM_HARTS-1:0] mode_vld_q;

	hsm_pkg::bk_state_t state_q, state_d;
	hsm_pkg::cmd_t      cmd_s1;
	logic [2:0]         mode_rd_s1;
	logic               vld_rd_s1;
	logic [63:0]        start_rd_s1;
	logic [63:0]        resume_rd_s1;
	logic [31:0]        skind_rd_s1;
	logic               rsp_valid_q;
	hsm_pkg::rsp_t      rsp_q;

	logic [IDX_W-1:0]   rd_idx;
	logic [IDX_W-1:0]   wr_idx;
	logic               fetch;
	logic               exec;
	hsm_pkg::hs_t       cur_mode;
	hsm_pkg::hs_t       new_mode;
	hsm_pkg::recon_t    rc;
	hsm_pkg::rsp_t      rsp_d;
	logic               wr_mode;
	logic               wr_start;
	logic               wr_susp;

	assign rd_idx = cmd.hart_idx[IDX_W-1:0];
	assign wr_idx = cmd_s1.hart_idx[IDX_W-1:0];

	// sequencer: fetch reads the table, exec writes it back
	always_comb begin
		state_d   = state_q;
		cmd_ready = 1'b0;
		fetch     = 1'b0;
		exec      = 1'b0;
		unique case (state_q)
			hsm_pkg::BK_FETCH: begin
				cmd_ready = 1'b1;
				if (cmd_valid) begin
					fetch   = 1'b1;
					state_d = hsm_pkg::BK_EXEC;
				end
			end
			hsm_pkg::BK_EXEC: begin
				if (!rsp_valid_q || rsp_ready) begin
					exec    = 1'b1;
					state_d = hsm_pkg::BK_FETCH;
				end
			end
			default: begin
				state_d = hsm_pkg::BK_FETCH;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= hsm_pkg::BK_FETCH;
		else
			state_q <= state_d;
	end

	// table read, registered
	always_ff @(posedge clk) begin
		if (fetch) begin
			cmd_s1       <= cmd;
			mode_rd_s1   <= mode_mem[rd_idx];
			vld_rd_s1    <= mode_vld_q[rd_idx];
			start_rd_s1  <= start_mem[rd_idx];
			resume_rd_s1 <= resume_mem[rd_idx];
			skind_rd_s1  <= skind_mem[rd_idx];
		end
	end

	assign cur_mode = vld_rd_s1 ? hsm_pkg::hs_t'(mode_rd_s1) : hsm_pkg::HS_UNKNOWN;

	// check and carry out the command
	always_comb begin
		rc                          = hsm_pkg::reconcile(cur_mode, cmd_s1.hw_sample);
		new_mode                    = cur_mode;
		wr_mode                     = 1'b0;
		wr_start                    = 1'b0;
		wr_susp                     = 1'b0;
		rsp_d.status                = hsm_pkg::RC_OK;
		rsp_d.finalize_kind         = hsm_pkg::EV_NONE;
		rsp_d.finalize_addr         = '0;
		rsp_d.finalize_suspend_kind = '0;
		if (!cmd_s1.func_ok) begin
			rsp_d.status = hsm_pkg::RC_UNSUPP;
		end else if (!cmd_s1.hart_ok) begin
			rsp_d.status = hsm_pkg::RC_INVALID;
		end else begin
			wr_mode = 1'b1;
			unique case (cmd_s1.func)
				hsm_pkg::FN_START: begin
					if (!cmd_s1.op_supported)
						rsp_d.status = hsm_pkg::RC_UNSUPP;
					else if (cur_mode == hsm_pkg::HS_STARTED ||
							cur_mode == hsm_pkg::HS_START_PEND)
						rsp_d.status = hsm_pkg::RC_ALREADY;
					else if (cur_mode != hsm_pkg::HS_STOPPED)
						rsp_d.status = hsm_pkg::RC_DENIED;
					else if (cmd_s1.prepare_fail)
						rsp_d.status = hsm_pkg::RC_PREPARE;
					else begin
						rc       = hsm_pkg::reconcile(hsm_pkg::HS_START_PEND,
							cmd_s1.hw_sample);
						new_mode = rc.mode;
						wr_start = 1'b1;
						rsp_d.finalize_kind = rc.ev;
						if (rc.ev == hsm_pkg::EV_START)
							rsp_d.finalize_addr = cmd_s1.target_addr;
					end
				end
				hsm_pkg::FN_STOP: begin
					if (!cmd_s1.op_supported)
						rsp_d.status = hsm_pkg::RC_UNSUPP;
					else if (cur_mode == hsm_pkg::HS_STOPPED ||
							cur_mode == hsm_pkg::HS_STOP_PEND)
						rsp_d.status = hsm_pkg::RC_ALREADY;
					else if (cur_mode != hsm_pkg::HS_STARTED)
						rsp_d.status = hsm_pkg::RC_DENIED;
					else if (cmd_s1.prepare_fail)
						rsp_d.status = hsm_pkg::RC_PREPARE;
					else begin
						rc       = hsm_pkg::reconcile(hsm_pkg::HS_STOP_PEND,
							cmd_s1.hw_sample);
						new_mode = rc.mode;
						rsp_d.finalize_kind = rc.ev;
					end
				end
				hsm_pkg::FN_SUSPEND: begin
					if (!cmd_s1.op_supported)
						rsp_d.status = hsm_pkg::RC_UNSUPP;
					else if (cur_mode == hsm_pkg::HS_SUSPENDED ||
							cur_mode == hsm_pkg::HS_SUSP_PEND)
						rsp_d.status = hsm_pkg::RC_ALREADY;
					else if (cur_mode != hsm_pkg::HS_STARTED)
						rsp_d.status = hsm_pkg::RC_DENIED;
					else if (cmd_s1.prepare_fail)
						rsp_d.status = hsm_pkg::RC_PREPARE;
					else begin
						rc       = hsm_pkg::reconcile(hsm_pkg::HS_SUSP_PEND,
							cmd_s1.hw_sample);
						new_mode = rc.mode;
						wr_susp  = 1'b1;
						rsp_d.finalize_kind = rc.ev;
						if (rc.ev == hsm_pkg::EV_SUSPEND) begin
							rsp_d.finalize_addr         = cmd_s1.target_addr;
							rsp_d.finalize_suspend_kind = cmd_s1.suspend_kind;
						end
					end
				end
				hsm_pkg::FN_QUERY: begin
					new_mode = cur_mode;
				end
				hsm_pkg::FN_POLL: begin
					new_mode            = rc.mode;
					rsp_d.finalize_kind = rc.ev;
					if (rc.ev == hsm_pkg::EV_START) begin
						rsp_d.finalize_addr = start_rd_s1;
					end else if (rc.ev == hsm_pkg::EV_SUSPEND) begin
						rsp_d.finalize_addr         = resume_rd_s1;
						rsp_d.finalize_suspend_kind = skind_rd_s1;
					end
				end
				default: begin
					new_mode = cur_mode;
				end
			endcase
		end
		rsp_d.hart_state = cmd_s1.hart_ok ? new_mode : hsm_pkg::HS_UNKNOWN;
	end

	// table write-back
	always_ff @(posedge clk) begin
		if (exec && wr_mode)
			mode_mem[wr_idx] <= new_mode;
		if (exec && wr_start)
			start_mem[wr_idx] <= cmd_s1.target_addr;
		if (exec && wr_susp) begin
			resume_mem[wr_idx] <= cmd_s1.target_addr;
			skind_mem[wr_idx]  <= cmd_s1.suspend_kind;
		end
	end

	// entry valid bits, unwritten entries read as unknown
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			mode_vld_q <= '0;
		else if (exec && wr_mode)
			mode_vld_q[wr_idx] <= 1'b1;
	end

	// response register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			rsp_valid_q <= 1'b0;
		else if (exec)
			rsp_valid_q <= 1'b1;
		else if (rsp_ready)
			rsp_valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (exec)
			rsp_q <= rsp_d;
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

endmodule

>>> rtl/hart_state_manager.sv
// ----------------------------------------------------------------------------
// hart_state_manager
// Per-hart software state tracking for start, stop, suspend, query and poll
// requests, with finalize events on reconciliation with the hardware state.
// ----------------------------------------------------------------------------
//  channel  | signals                          | direction
//  ---------+----------------------------------+-----------
//  request  | req_valid, req_ready, req        | in
//  response | rsp_valid, rsp_ready, rsp        | out
//  config   | cfg_we, cfg_index, cfg_wdata     | in
//
//  in the back end a fetch step reads the hart state table for each beat,
//  and an exec step checks, writes back and loads the response register.
//  a two-entry queue lets the front take beats while the back is busy.
//  reset clears the hart states to unknown and the registers to their
//  defaults; the table needs no clearing pass.
//  a stalled response holds the back end in its write-back step.
// ----------------------------------------------------------------------------
module hart_state_manager #(
	parameter int unsigned NUM_HARTS = 8
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          req_valid,
	output logic          req_ready,
	input  hsm_pkg::req_t req,
	output logic          rsp_valid,
	input  logic          rsp_ready,
	output hsm_pkg::rsp_t rsp,
	input  logic          cfg_we,
	input  logic [1:0]    cfg_index,
	input  logic [31:0]   cfg_wdata
);

	hsm_pkg::cfg_t cfg_q;
	hsm_pkg::cmd_t push_cmd;
	hsm_pkg::cmd_t pop_cmd;
	logic          push_valid;
	logic          push_ready;
	logic          pop_valid;
	logic          pop_ready;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.harts_used    <= 4'd8;
			cfg_q.id_base       <= 32'd0;
			cfg_q.supported_ops <= 3'd7;
		end else if (cfg_we) begin
			if (cfg_index == hsm_pkg::CFG_HART_COUNT)
				cfg_q.harts_used <= cfg_wdata[3:0];
			else if (cfg_index == hsm_pkg::CFG_ID_BASE)
				cfg_q.id_base <= cfg_wdata;
			else if (cfg_index == hsm_pkg::CFG_SUPPORTED_OPS)
				cfg_q.supported_ops <= cfg_wdata[2:0];
		end
	end

	// request classification
	hsm_front #(
		.NUM_HARTS(NUM_HARTS)
	) u_front (
		.req_valid (req_valid),
		.req_ready (req_ready),
		.req       (req),
		.cfg       (cfg_q),
		.push_valid(push_valid),
		.push_ready(push_ready),
		.cmd       (push_cmd)
	);

	// command queue
	hsm_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push_valid(push_valid),
		.push_ready(push_ready),
		.push_cmd  (push_cmd),
		.pop_valid (pop_valid),
		.pop_ready (pop_ready),
		.pop_cmd   (pop_cmd)
	);

	// state table and execution
	hsm_back #(
		.NUM_HARTS(NUM_HARTS)
	) u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd_valid(pop_valid),
		.cmd_ready(pop_ready),
		.cmd      (pop_cmd),
		.rsp_valid(rsp_valid),
		.rsp_ready(rsp_ready),
		.rsp      (rsp)
	);

endmodule

>>> tb/tb_hart_state_manager.sv
// ----------------------------------------------------------------------------
// tb_hart_state_manager
// Self-checking bench for the hart state manager. Requests go in over a
// valid/ready channel with random gaps. Each accepted beat updates a local
// per-hart state table, and the response it should produce is queued. Each
// response beat is compared field by field with the oldest queued response.
// A short directed table runs first, then random request sequences under
// several register settings, with a long response stall and a full drain.
// ----------------------------------------------------------------------------
module tb_hart_state_manager;

	localparam int unsigned NUM_HARTS    = 8;
	localparam int unsigned HOLD_CYCLES  = 60;
	localparam int unsigned DRAIN_CYCLES = 10;
	localparam int unsigned CYCLE_LIMIT  = 300000;

	// codes with no name in the package
	localparam logic [1:0] CFG_IDX_UNUSED = 2'd3;
	localparam logic [2:0] FN_UNUSED_LO   = 3'd5;
	localparam logic [2:0] FN_UNUSED_HI   = 3'd7;
	localparam logic [1:0] HW_NONE        = 2'd3;

	typedef struct {
		hsm_pkg::req_t r;
		bit            typed;
		hsm_pkg::rsp_t want;
	} dir_row_t;

	logic          clk       = 1'b0;
	logic          arst_n    = 1'b0;
	logic          req_valid = 1'b0;
	logic          req_ready;
	hsm_pkg::req_t req       = '0;
	logic          rsp_valid;
	logic          rsp_ready = 1'b0;
	hsm_pkg::rsp_t rsp;
	logic          cfg_we    = 1'b0;
	logic [1:0]    cfg_index = '0;
	logic [31:0]   cfg_wdata = '0;

	// local copy of the block's registers and hart table
	logic [3:0]   cfg_harts;
	logic [31:0]  cfg_base;
	logic [2:0]   cfg_ops;
	hsm_pkg::hs_t mode_tab[NUM_HARTS];
	logic [63:0]  start_addr_tab[NUM_HARTS];
	logic [63:0]  resume_addr_tab[NUM_HARTS];
	logic [31:0]  susp_kind_tab[NUM_HARTS];

	hsm_pkg::rsp_t pending_hart_rsps[$];
	int unsigned   errors     = 0;
	int unsigned   cycles     = 0;
	int unsigned   stall_left = 0;
	bit            steady     = 1'b0;
	bit            offering   = 1'b0;

	hart_state_manager #(
		.NUM_HARTS(NUM_HARTS)
	) dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.req_valid(req_valid),
		.req_ready(req_ready),
		.req      (req),
		.rsp_valid(rsp_valid),
		.rsp_ready(rsp_ready),
		.rsp      (rsp),
		.cfg_we   (cfg_we),
		.cfg_index(cfg_index),
		.cfg_wdata(cfg_wdata)
	);

	// clock
	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	// run limit
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("tb_hart_state_manager: done, errors");
			$finish;
		end
	end

	function automatic int unsigned harts_in_use();
		return (cfg_harts > NUM_HARTS) ? NUM_HARTS : 32'(cfg_harts);
	endfunction

	function automatic hsm_pkg::req_t mk_req(logic [2:0] fn, logic [31:0] id,
			logic [63:0] addr, logic [31:0] kind, logic pfail, logic [1:0] hw);
		hsm_pkg::req_t r;
		r.func         = fn;
		r.hart_id      = id;
		r.target_addr  = addr;
		r.suspend_kind = kind;
		r.prepare_fail = pfail;
		r.hw_sample    = hw;
		return r;
	endfunction

	function automatic hsm_pkg::rsp_t mk_rsp(hsm_pkg::rc_t rc, hsm_pkg::hs_t hs);
		hsm_pkg::rsp_t o;
		o            = '0;
		o.status     = rc;
		o.hart_state = hs;
		return o;
	endfunction

	// settle a hart against the sampled hardware state
	function automatic void settle_hart(int unsigned h, logic [1:0] hw,
			inout hsm_pkg::rsp_t o);
		case (mode_tab[h])
			hsm_pkg::HS_UNKNOWN: begin
				if (hw == hsm_pkg::HW_STARTED)
					mode_tab[h] = hsm_pkg::HS_STARTED;
				else if (hw == hsm_pkg::HW_SUSPENDED)
					mode_tab[h] = hsm_pkg::HS_SUSPENDED;
				else
					mode_tab[h] = hsm_pkg::HS_STOPPED;
			end
			hsm_pkg::HS_START_PEND: begin
				if (hw == hsm_pkg::HW_STARTED) begin
					o.finalize_kind = hsm_pkg::EV_START;
					o.finalize_addr = start_addr_tab[h];
					mode_tab[h]     = hsm_pkg::HS_STARTED;
				end
			end
			hsm_pkg::HS_STOP_PEND: begin
				if (hw == hsm_pkg::HW_STOPPED || hw == hsm_pkg::HW_SUSPENDED) begin
					o.finalize_kind = hsm_pkg::EV_STOP;
					mode_tab[h]     = hsm_pkg::HS_STOPPED;
				end
			end
			hsm_pkg::HS_SUSP_PEND: begin
				if (hw == hsm_pkg::HW_SUSPENDED) begin
					o.finalize_kind         = hsm_pkg::EV_SUSPEND;
					o.finalize_addr         = resume_addr_tab[h];
					o.finalize_suspend_kind = susp_kind_tab[h];
					mode_tab[h]             = hsm_pkg::HS_SUSPENDED;
				end
			end
			hsm_pkg::HS_SUSPENDED: begin
				if (hw == hsm_pkg::HW_STARTED)
					mode_tab[h] = hsm_pkg::HS_STARTED;
			end
			default: ;
		endcase
	endfunction

	// apply one request to the local hart table, return the response it gives
	function automatic hsm_pkg::rsp_t hsm_apply(hsm_pkg::req_t r);
		hsm_pkg::rsp_t o;
		logic [31:0]   idx;
		int unsigned   h;
		bit            in_range;
		hsm_pkg::hs_t  cur;
		hsm_pkg::rc_t  rc;
		o        = '0;
		idx      = r.hart_id - cfg_base;
		in_range = (idx < harts_in_use());
		h        = in_range ? idx : 0;
		if (r.func > hsm_pkg::FN_POLL) begin
			o.status = hsm_pkg::RC_UNSUPP;
			if (in_range)
				o.hart_state = mode_tab[h];
			return o;
		end
		if (!in_range) begin
			o.status = hsm_pkg::RC_INVALID;
			return o;
		end
		cur = mode_tab[h];
		rc  = hsm_pkg::RC_OK;
		case (r.func)
			hsm_pkg::FN_START: begin
				if (!cfg_ops[0])
					rc = hsm_pkg::RC_UNSUPP;
				else if (cur == hsm_pkg::HS_STARTED || cur == hsm_pkg::HS_START_PEND)
					rc = hsm_pkg::RC_ALREADY;
				else if (cur != hsm_pkg::HS_STOPPED)
					rc = hsm_pkg::RC_DENIED;
				else if (r.prepare_fail)
					rc = hsm_pkg::RC_PREPARE;
				else begin
					start_addr_tab[h] = r.target_addr;
					mode_tab[h]       = hsm_pkg::HS_START_PEND;
					settle_hart(h, r.hw_sample, o);
				end
			end
			hsm_pkg::FN_STOP: begin
				if (!cfg_ops[1])
					rc = hsm_pkg::RC_UNSUPP;
				else if (cur == hsm_pkg::HS_STOPPED || cur == hsm_pkg::HS_STOP_PEND)
					rc = hsm_pkg::RC_ALREADY;
				else if (cur != hsm_pkg::HS_STARTED)
					rc = hsm_pkg::RC_DENIED;
				else if (r.prepare_fail)
					rc = hsm_pkg::RC_PREPARE;
				else begin
					mode_tab[h] = hsm_pkg::HS_STOP_PEND;
					settle_hart(h, r.hw_sample, o);
				end
			end
			hsm_pkg::FN_SUSPEND: begin
				if (!cfg_ops[2])
					rc = hsm_pkg::RC_UNSUPP;
				else if (cur == hsm_pkg::HS_SUSPENDED || cur == hsm_pkg::HS_SUSP_PEND)
					rc = hsm_pkg::RC_ALREADY;
				else if (cur != hsm_pkg::HS_STARTED)
					rc = hsm_pkg::RC_DENIED;
				else if (r.prepare_fail)
					rc = hsm_pkg::RC_PREPARE;
				else begin
					susp_kind_tab[h]   = r.suspend_kind;
					resume_addr_tab[h] = r.target_addr;
					mode_tab[h]        = hsm_pkg::HS_SUSP_PEND;
					settle_hart(h, r.hw_sample, o);
				end
			end
			hsm_pkg::FN_POLL: settle_hart(h, r.hw_sample, o);
			default: ;
		endcase
		o.status     = rc;
		o.hart_state = mode_tab[h];
		return o;
	endfunction

	// mostly requests that move a hart along its life cycle, some noise
	function automatic hsm_pkg::req_t next_random_request();
		hsm_pkg::req_t r;
		int unsigned   lim;
		int unsigned   h;
		r              = '0;
		r.target_addr  = {$urandom, $urandom};
		r.suspend_kind = $urandom;
		r.prepare_fail = ($urandom_range(0, 15) == 0);
		r.hw_sample    = 2'($urandom_range(0, 3));
		lim            = harts_in_use();
		if (lim == 0 || $urandom_range(0, 99) < 10) begin
			case ($urandom_range(0, 2))
				0: r.hart_id = $urandom;
				1: r.hart_id = cfg_base + lim;
				default: r.hart_id = cfg_base - 1;
			endcase
			r.func = 3'($urandom_range(0, 7));
			return r;
		end
		h         = $urandom_range(0, lim - 1);
		r.hart_id = cfg_base + h;
		if ($urandom_range(0, 99) < 20) begin
			r.func = 3'($urandom_range(0, 7));
			return r;
		end
		case (mode_tab[h])
			hsm_pkg::HS_STOPPED: begin
				r.func = hsm_pkg::FN_START;
				if ($urandom_range(0, 99) < 60)
					r.hw_sample = hsm_pkg::HW_STARTED;
			end
			hsm_pkg::HS_STARTED: begin
				r.func = $urandom_range(0, 1) ? hsm_pkg::FN_STOP : hsm_pkg::FN_SUSPEND;
				if ($urandom_range(0, 99) < 60)
					r.hw_sample = (r.func == hsm_pkg::FN_STOP) ?
						hsm_pkg::HW_STOPPED : hsm_pkg::HW_SUSPENDED;
			end
			hsm_pkg::HS_START_PEND: begin
				r.func = hsm_pkg::FN_POLL;
				if ($urandom_range(0, 99) < 60)
					r.hw_sample = hsm_pkg::HW_STARTED;
			end
			hsm_pkg::HS_STOP_PEND: begin
				r.func = hsm_pkg::FN_POLL;
				if ($urandom_range(0, 99) < 60)
					r.hw_sample = $urandom_range(0, 1) ?
						hsm_pkg::HW_STOPPED : hsm_pkg::HW_SUSPENDED;
			end
			hsm_pkg::HS_SUSP_PEND: begin
				r.func = hsm_pkg::FN_POLL;
				if ($urandom_range(0, 99) < 60)
					r.hw_sample = hsm_pkg::HW_SUSPENDED;
			end
			hsm_pkg::HS_SUSPENDED: begin
				r.func = hsm_pkg::FN_POLL;
				if ($urandom_range(0, 99) < 60)
					r.hw_sample = hsm_pkg::HW_STARTED;
			end
			default: r.func = hsm_pkg::FN_POLL;
		endcase
		return r;
	endfunction

	task automatic report_mismatch(input string what, input logic [63:0] got,
			input logic [63:0] want);
		$display("%0t: mismatch %s: got %0h want %0h", $realtime, what, got, want);
		errors++;
	endtask

	// compare one response beat with the oldest expected one
	task automatic check_rsp(input hsm_pkg::rsp_t got);
		hsm_pkg::rsp_t want;
		if (pending_hart_rsps.size() == 0) begin
			report_mismatch("response beat with none outstanding", 64'(got.status), '0);
			return;
		end
		want = pending_hart_rsps.pop_front();
		if (got.status !== want.status)
			report_mismatch("status", 64'(got.status), 64'(want.status));
		if (got.hart_state !== want.hart_state)
			report_mismatch("hart_state", 64'(got.hart_state), 64'(want.hart_state));
		if (got.finalize_kind !== want.finalize_kind)
			report_mismatch("finalize_kind", 64'(got.finalize_kind),
				64'(want.finalize_kind));
		if (got.finalize_addr !== want.finalize_addr)
			report_mismatch("finalize_addr", got.finalize_addr, want.finalize_addr);
		if (got.finalize_suspend_kind !== want.finalize_suspend_kind)
			report_mismatch("finalize_suspend_kind", 64'(got.finalize_suspend_kind),
				64'(want.finalize_suspend_kind));
	endtask

	// response side: check beats, random back-pressure, long hold on request
	always @(posedge clk) begin
		if (arst_n) begin
			if (rsp_valid && rsp_ready)
				check_rsp(rsp);
			if (stall_left > 0) begin
				rsp_ready  <= 1'b0;
				stall_left = stall_left - 1;
			end else begin
				rsp_ready <= steady || ($urandom_range(0, 99) >= 14);
			end
		end
	end

	// offer one request beat and hold it until accepted
	task automatic offer_request(input hsm_pkg::req_t r, input bit typed,
			input hsm_pkg::rsp_t want);
		hsm_pkg::rsp_t pred;
		req       <= r;
		req_valid <= 1'b1;
		offering  = 1'b1;
		do
			@(posedge clk);
		while (!req_ready);
		pred = hsm_apply(r);
		pending_hart_rsps.push_back(typed ? want : pred);
		if (!steady && $urandom_range(0, 99) < 14) begin
			req_valid <= 1'b0;
			offering  = 1'b0;
			repeat ($urandom_range(1, 3)) @(posedge clk);
		end
	endtask

	// drop valid, wait for every response, then let the block settle
	task automatic quiesce(input int unsigned settle);
		if (offering) begin
			req_valid <= 1'b0;
			offering  = 1'b0;
		end
		while (pending_hart_rsps.size() != 0)
			@(posedge clk);
		repeat (settle) @(posedge clk);
	endtask

	task automatic write_reg(input logic [1:0] idx, input logic [31:0] val);
		cfg_index <= idx;
		cfg_wdata <= val;
		cfg_we    <= 1'b1;
		@(posedge clk);
		case (idx)
			hsm_pkg::CFG_HART_COUNT:    cfg_harts = val[3:0];
			hsm_pkg::CFG_ID_BASE:       cfg_base  = val;
			hsm_pkg::CFG_SUPPORTED_OPS: cfg_ops   = val[2:0];
			default: ;
		endcase
		cfg_we <= 1'b0;
		@(posedge clk);
	endtask

	task automatic configure(input logic [3:0] harts, input logic [31:0] base,
			input logic [2:0] ops);
		quiesce(DRAIN_CYCLES);
		write_reg(hsm_pkg::CFG_HART_COUNT, {28'd0, harts});
		write_reg(hsm_pkg::CFG_ID_BASE, base);
		write_reg(hsm_pkg::CFG_SUPPORTED_OPS, {29'd0, ops});
	endtask

	task automatic run_phase(input int unsigned n, input bit no_gaps, input bit hold,
			input bit pause);
		steady = no_gaps;
		for (int unsigned i = 0; i < n; i++) begin
			// receiver holds off while requests keep coming
			if (hold && i == 8)
				stall_left = HOLD_CYCLES;
			// sender waits for every outstanding response
			if (pause && i == n / 2)
				quiesce(0);
			offer_request(next_random_request(), 1'b0, '0);
		end
		steady = 1'b0;
	endtask

	initial begin
		dir_row_t rows[$];
		// local copy of the reset state
		cfg_harts = 4'd8;
		cfg_base  = '0;
		cfg_ops   = 3'd7;
		for (int i = 0; i < NUM_HARTS; i++) begin
			mode_tab[i]        = hsm_pkg::HS_UNKNOWN;
			start_addr_tab[i]  = '0;
			resume_addr_tab[i] = '0;
			susp_kind_tab[i]   = '0;
		end

		// directed table: every hart starts unknown
		rows.push_back('{mk_req(hsm_pkg::FN_QUERY, 0, 0, 0, 0, hsm_pkg::HW_STARTED), 1,
			mk_rsp(hsm_pkg::RC_OK, hsm_pkg::HS_UNKNOWN)});
		rows.push_back('{mk_req(hsm_pkg::FN_START, 0, 0, 0, 0, hsm_pkg::HW_STARTED), 1,
			mk_rsp(hsm_pkg::RC_DENIED, hsm_pkg::HS_UNKNOWN)});
		rows.push_back('{mk_req(hsm_pkg::FN_STOP, 1, 0, 0, 0, hsm_pkg::HW_STOPPED), 1,
			mk_rsp(hsm_pkg::RC_DENIED, hsm_pkg::HS_UNKNOWN)});
		rows.push_back('{mk_req(hsm_pkg::FN_SUSPEND, 2, 0, 0, 0, hsm_pkg::HW_SUSPENDED), 1,
			mk_rsp(hsm_pkg::RC_DENIED, hsm_pkg::HS_UNKNOWN)});
		rows.push_back('{mk_req(FN_UNUSED_LO, 0, 0, 0, 0, hsm_pkg::HW_STARTED), 1,
			mk_rsp(hsm_pkg::RC_UNSUPP, hsm_pkg::HS_UNKNOWN)});
		rows.push_back('{mk_req(FN_UNUSED_HI, 32'hFFFF_FFFF, '1, '1, 1, HW_NONE), 1,
			mk_rsp(hsm_pkg::RC_UNSUPP, hsm_pkg::HS_UNKNOWN)});
		rows.push_back('{mk_req(hsm_pkg::FN_QUERY, 8, 0, 0, 0, hsm_pkg::HW_STARTED), 1,
			mk_rsp(hsm_pkg::RC_INVALID, hsm_pkg::HS_UNKNOWN)});
		rows.push_back('{mk_req(hsm_pkg::FN_START, 32'hFFFF_FFFF, 0, 0, 0,
			hsm_pkg::HW_STARTED), 1, mk_rsp(hsm_pkg::RC_INVALID, hsm_pkg::HS_UNKNOWN)});
		// polls resolve the unknown state from the hardware
		rows.push_back('{mk_req(hsm_pkg::FN_POLL, 0, 0, 0, 0, hsm_pkg::HW_STARTED), 1,
			mk_rsp(hsm_pkg::RC_OK, hsm_pkg::HS_STARTED)});
		rows.push_back('{mk_req(hsm_pkg::FN_POLL, 1, 0, 0, 0, hsm_pkg::HW_STOPPED), 1,
			mk_rsp(hsm_pkg::RC_OK, hsm_pkg::HS_STOPPED)});
		rows.push_back('{mk_req(hsm_pkg::FN_POLL, 2, 0, 0, 0, hsm_pkg::HW_SUSPENDED), 1,
			mk_rsp(hsm_pkg::RC_OK, hsm_pkg::HS_SUSPENDED)});
		rows.push_back('{mk_req(hsm_pkg::FN_POLL, 3, 0, 0, 0, HW_NONE), 1,
			mk_rsp(hsm_pkg::RC_OK, hsm_pkg::HS_STOPPED)});
		rows.push_back('{mk_req(hsm_pkg::FN_START, 0, 0, 0, 0, hsm_pkg::HW_STARTED), 1,
			mk_rsp(hsm_pkg::RC_ALREADY, hsm_pkg::HS_STARTED)});
		rows.push_back('{mk_req(hsm_pkg::FN_START, 1, 0, 0, 1, hsm_pkg::HW_STARTED), 1,
			mk_rsp(hsm_pkg::RC_PREPARE, hsm_pkg::HS_STOPPED)});
		// full transitions, pending then finalized
		rows.push_back('{mk_req(hsm_pkg::FN_START, 1, '1, 0, 0, hsm_pkg::HW_STOPPED),
			0, '0});
		rows.push_back('{mk_req(hsm_pkg::FN_POLL, 1, 0, 0, 0, hsm_pkg::HW_STARTED),
			0, '0});
		rows.push_back('{mk_req(hsm_pkg::FN_START, 3, 0, '1, 0, hsm_pkg::HW_STARTED),
			0, '0});
		rows.push_back('{mk_req(hsm_pkg::FN_SUSPEND, 0, 64'h8000_0000_0000_0001, '1, 0,
			hsm_pkg::HW_STOPPED), 0, '0});
		rows.push_back('{mk_req(hsm_pkg::FN_SUSPEND, 0, 0, 0, 0, hsm_pkg::HW_STOPPED),
			0, '0});
		rows.push_back('{mk_req(hsm_pkg::FN_STOP, 0, 0, 0, 0, hsm_pkg::HW_STOPPED),
			0, '0});
		rows.push_back('{mk_req(hsm_pkg::FN_POLL, 0, 0, 0, 0, hsm_pkg::HW_SUSPENDED),
			0, '0});
		rows.push_back('{mk_req(hsm_pkg::FN_POLL, 0, 0, 0, 0, hsm_pkg::HW_STARTED),
			0, '0});
		rows.push_back('{mk_req(hsm_pkg::FN_STOP, 0, 0, 0, 0, hsm_pkg::HW_STARTED),
			0, '0});
		rows.push_back('{mk_req(hsm_pkg::FN_QUERY, 0, 0, 0, 0, HW_NONE), 0, '0});
		rows.push_back('{mk_req(hsm_pkg::FN_POLL, 0, 0, 0, 0, hsm_pkg::HW_SUSPENDED),
			0, '0});
		rows.push_back('{mk_req(hsm_pkg::FN_STOP, 2, 0, 0, 0, hsm_pkg::HW_STOPPED),
			0, '0});

		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (rows[k])
			offer_request(rows[k].r, rows[k].typed, rows[k].want);

		// random sequences under several register settings
		run_phase(110, 1'b0, 1'b1, 1'b0);
		configure(4'd1, 32'hFFFF_FFFF, 3'd7);
		run_phase(80, 1'b0, 1'b0, 1'b0);
		configure(4'd15, 32'hFFFF_FFFC, 3'd7);
		run_phase(110, 1'b0, 1'b0, 1'b1);
		configure(4'd0, $urandom, 3'd7);
		run_phase(40, 1'b0, 1'b0, 1'b0);
		configure(4'd3, $urandom, 3'd0);
		run_phase(70, 1'b0, 1'b0, 1'b0);
		// a write to the unused index changes nothing
		quiesce(DRAIN_CYCLES);
		write_reg(CFG_IDX_UNUSED, $urandom);
		run_phase(50, 1'b0, 1'b0, 1'b0);
		configure(4'd8, $urandom, 3'd5);
		run_phase(110, 1'b1, 1'b0, 1'b0);
		configure(4'd6, $urandom, 3'd3);
		run_phase(90, 1'b0, 1'b0, 1'b0);
		configure(4'd8, 32'd0, 3'd7);
		run_phase(90, 1'b0, 1'b1, 1'b0);

		quiesce(DRAIN_CYCLES);
		if (errors == 0)
			$display("tb_hart_state_manager: done, clean");
		else
			$display("tb_hart_state_manager: done, errors");
		$finish;
	end

endmodule
